// ===== sv/srx_pkg.sv =====
// srx_pkg: shared codes and the status record of the stx/etx message receiver
`timescale 1ns / 1ps

package srx_pkg;

    // item kinds on the input tuser
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // framing bytes
    localparam logic [7:0] CODE_STX = 8'h02;
    localparam logic [7:0] CODE_ETX = 8'h03;

    // packed widths of the stream payloads
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // per-item status handed from the control stage to the read stage
    typedef struct packed {
        logic [7:0] oldest_length;
        logic [1:0] messages_stored;
        logic       frame_committed;
        logic       full_fault;
        logic       line_too_long;
        logic       rd_hit;
    } status_t;

endpackage

// ===== sv/stx_etx_message_receiver.sv =====
// stx_etx_message_receiver: top level of the stx/etx framed message receiver
`timescale 1ns / 1ps

// Takes one item per cycle while results are taken. Acceptance updates the
// line and slot ring state and issues the message memory access; the read
// stage then holds the item's status beside the registered memory read data,
// and the result register holds the item until taken.
// Bytes other than STX and ETX are written straight into the free slot
// of a ring of SLOTS slots of SLOT_BYTES bytes; ETX commits the line if fewer
// than SLOTS-1 messages are stored, else sets the sticky full fault. Reads
// return a byte of the oldest message (0 past its end), releases free it.
// The message memory needs no clearing after reset; bytes never written are
// never read back.
module stx_etx_message_receiver #(
    parameter int SLOTS      = 4,
    parameter int SLOT_BYTES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srx_pkg::S_TDATA_W-1:0] s_tdata,   // rx_byte, read_offset
    input  logic [srx_pkg::S_TUSER_W-1:0] s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_data, oldest_length, messages_stored, frame_committed,
    // full_fault, line_too_long, zero fill
    output logic [srx_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH = SLOTS * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic             accept;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [7:0]       mem_rd_data;
    srx_pkg::status_t status;

    assign accept = s_tvalid && s_tready;

    // per-item state update and memory addressing
    srx_ctrl #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .kind        (s_tuser[1:0]),
        .rx_byte     (s_tdata[7:0]),
        .read_offset (s_tdata[15:8]),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .status      (status)
    );

    // message bytes
    srx_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // read stage and result register
    srx_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .status    (status),
        .rd_data   (mem_rd_data),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // input side never stalls while the result register is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // a committed frame always leaves at least one message stored
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[18]) |-> (m_tdata[17:16] != 2'd0 || SLOTS > 4))
        else $error("commit reported with no stored message");

    // a non-zero oldest length needs a stored message
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:8] != 8'd0) |-> (m_tdata[17:16] != 2'd0 || SLOTS > 4))
        else $error("oldest length reported with no stored message");

    // the full fault stays set on every later item
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(m_tvalid && m_tready && m_tdata[19]) && m_tvalid) |-> m_tdata[19])
        else $error("full fault flag cleared");

endmodule

// ===== sv/srx_store.sv =====
// srx_store: message byte memory, one write port and one registered read port
`timescale 1ns / 1ps

module srx_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/srx_ctrl.sv =====
// srx_ctrl: line collection, slot ring bookkeeping and memory addressing per item
`timescale 1ns / 1ps

module srx_ctrl #(
    parameter int SLOTS      = 4,
    parameter int SLOT_BYTES = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [1:0]                          kind,
    input  logic [7:0]                          rx_byte,
    input  logic [7:0]                          read_offset,
    output logic                                mem_wr_en,
    output logic [$clog2(SLOTS*SLOT_BYTES)-1:0] mem_wr_addr,
    output logic [7:0]                          mem_wr_data,
    output logic                                mem_rd_en,
    output logic [$clog2(SLOTS*SLOT_BYTES)-1:0] mem_rd_addr,
    output srx_pkg::status_t                    status
);

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(SLOT_BYTES);
    localparam int CW    = (LW > 8) ? LW : 8;
    localparam int AW    = $clog2(SLOTS * SLOT_BYTES);

    logic [SW-1:0] wr_slot_reg, wr_slot_next;
    logic [SW-1:0] rd_slot_reg, rd_slot_next;
    logic [SW-1:0] count_reg, count_next;
    logic [LW-1:0] line_len_reg, line_len_next;
    logic [LW-1:0] head_len_reg, head_len_next;
    logic          fault_reg, fault_next;
    logic          too_long_reg, too_long_next;
    logic [LW-1:0] slot_len_reg [SLOTS];

    logic [SW-1:0] wr_slot_inc;
    logic [SW-1:0] rd_slot_inc;
    logic [LW-1:0] byte_idx;
    logic          byte_wr;
    logic          slot_we;
    logic          committed;
    logic          rd_hit;

    // ring pointer increments with wrap at SLOTS
    assign wr_slot_inc = (wr_slot_reg == SW'(SLOTS - 1)) ? '0 : wr_slot_reg + SW'(1);
    assign rd_slot_inc = (rd_slot_reg == SW'(SLOTS - 1)) ? '0 : rd_slot_reg + SW'(1);

    // next state for the item at the input
    always_comb begin
        wr_slot_next  = wr_slot_reg;
        rd_slot_next  = rd_slot_reg;
        count_next    = count_reg;
        line_len_next = line_len_reg;
        head_len_next = head_len_reg;
        fault_next    = fault_reg;
        too_long_next = too_long_reg;
        byte_idx      = line_len_reg;
        byte_wr       = 1'b0;
        slot_we       = 1'b0;
        committed     = 1'b0;
        case (kind)
            srx_pkg::KIND_BYTE: begin
                if (rx_byte == srx_pkg::CODE_STX) begin
                    line_len_next = '0;
                end else if (rx_byte == srx_pkg::CODE_ETX) begin
                    if (count_reg >= SW'(SLOTS - 1)) begin
                        fault_next = 1'b1;
                    end else begin
                        slot_we      = 1'b1;
                        committed    = 1'b1;
                        wr_slot_next = wr_slot_inc;
                        count_next   = count_reg + SW'(1);
                        if (count_reg == '0) begin
                            head_len_next = line_len_reg;
                        end
                    end
                    line_len_next = '0;
                end else begin
                    byte_wr = 1'b1;
                    if (line_len_reg >= LW'(SLOT_BYTES - 1)) begin
                        // line overflow: restart it with this byte
                        too_long_next = 1'b1;
                        byte_idx      = '0;
                        line_len_next = LW'(1);
                    end else begin
                        line_len_next = line_len_reg + LW'(1);
                    end
                end
            end
            srx_pkg::KIND_RELEASE: begin
                if (count_reg != '0) begin
                    count_next   = count_reg - SW'(1);
                    rd_slot_next = rd_slot_inc;
                    if (count_reg == SW'(1)) begin
                        head_len_next = '0;
                    end else begin
                        head_len_next = slot_len_reg[rd_slot_inc];
                    end
                end
            end
            default: begin
                // reads and unused kinds leave the state alone
            end
        endcase
    end

    // read hits only bytes below the oldest message length
    assign rd_hit = (kind == srx_pkg::KIND_READ) && (count_reg != '0)
                    && (CW'(read_offset) < CW'(head_len_reg));

    // memory addressing
    assign mem_wr_en   = accept && byte_wr;
    assign mem_wr_addr = AW'(wr_slot_reg) * AW'(SLOT_BYTES) + AW'(byte_idx);
    assign mem_wr_data = rx_byte;
    assign mem_rd_en   = accept && rd_hit;
    assign mem_rd_addr = AW'(rd_slot_reg) * AW'(SLOT_BYTES) + AW'(read_offset);

    // status after this item
    always_comb begin
        status.oldest_length   = 8'(head_len_next);
        status.messages_stored = 2'(count_next);
        status.frame_committed = committed;
        status.full_fault      = fault_next;
        status.line_too_long   = too_long_next;
        status.rd_hit          = rd_hit;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg  <= '0;
            rd_slot_reg  <= '0;
            count_reg    <= '0;
            line_len_reg <= '0;
            head_len_reg <= '0;
            fault_reg    <= 1'b0;
            too_long_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_len_reg[i] <= '0;
            end
        end else if (accept) begin
            wr_slot_reg  <= wr_slot_next;
            rd_slot_reg  <= rd_slot_next;
            count_reg    <= count_next;
            line_len_reg <= line_len_next;
            head_len_reg <= head_len_next;
            fault_reg    <= fault_next;
            too_long_reg <= too_long_next;
            if (slot_we) begin
                slot_len_reg[wr_slot_reg] <= line_len_reg;
            end
        end
    end

endmodule

// ===== sv/srx_out.sv =====
// srx_out: memory read stage and result register with stream handshake
`timescale 1ns / 1ps

module srx_out (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  srx_pkg::status_t                status,
    input  logic [7:0]                      rd_data,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srx_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                          mid_valid_reg;
    srx_pkg::status_t              mid_status_reg;
    logic                          out_valid_reg;
    logic [srx_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                          mid_adv;
    logic [7:0]                    read_byte;

    // the read stage moves on whenever the result register is free or draining
    assign mid_adv  = mid_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !mid_valid_reg || mid_adv;

    assign read_byte = mid_status_reg.rd_hit ? rd_data : 8'd0;

    // read stage and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                mid_valid_reg <= 1'b1;
            end else if (mid_adv) begin
                mid_valid_reg <= 1'b0;
            end
            if (mid_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (in_accept) begin
            mid_status_reg <= status;
        end
        if (mid_adv) begin
            out_data_reg <= {3'b000,
                             mid_status_reg.line_too_long,
                             mid_status_reg.full_fault,
                             mid_status_reg.frame_committed,
                             mid_status_reg.messages_stored,
                             mid_status_reg.oldest_length,
                             read_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/sv/stx_etx_message_receiver_test.sv =====
// stx_etx_message_receiver_test: self-checking stream testbench of the stx/etx message receiver
`timescale 1ns / 1ps

module stx_etx_message_receiver_test;

    localparam int SLOTS        = 4;
    localparam int SLOT_BYTES   = 256;
    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 10;

    // reserved kind, the block only reports status for it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one result item as the block reports it
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] oldest_length;
        logic [1:0] messages_stored;
        logic       frame_committed;
        logic       full_fault;
        logic       line_too_long;
    } rx_status_t;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [srx_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // rx_byte, read_offset
    logic [srx_pkg::S_TUSER_W-1:0] s_tuser  = '0;   // kind
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // read_data, oldest_length, messages_stored, frame_committed,
    // full_fault, line_too_long, zero fill
    logic [srx_pkg::M_TDATA_W-1:0] m_tdata;

    stx_etx_message_receiver #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted receiver state
    logic [7:0]  msg_mem [SLOTS*SLOT_BYTES];
    int unsigned slot_len [SLOTS];
    int unsigned wr_slot       = 0;
    int unsigned n_stored      = 0;
    int unsigned line_len      = 0;
    logic        fault_seen    = 1'b0;
    logic        overlong_seen = 1'b0;

    rx_status_t  expected_status_q [$];
    int unsigned items_sent  = 0;
    int unsigned mismatches  = 0;
    logic        tx_idle_on  = 1'b1;
    logic        rx_stall_on = 1'b1;
    int unsigned stall_left  = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned oldest_slot_idx();
        return (wr_slot + SLOTS - n_stored) % SLOTS;
    endfunction

    function automatic int unsigned oldest_len();
        return (n_stored > 0) ? slot_len[oldest_slot_idx()] : 0;
    endfunction

    // advance the predicted state by one item and return its status
    function automatic rx_status_t predict_status(logic [1:0] kind, logic [7:0] rx,
                                                  logic [7:0] off);
        rx_status_t  r;
        int unsigned held;
        r    = '0;
        held = n_stored;
        case (kind)
            srx_pkg::KIND_BYTE: begin
                if (rx == srx_pkg::CODE_STX) begin
                    line_len = 0;
                end else if (rx == srx_pkg::CODE_ETX) begin
                    // commit only while one slot stays free for the next line
                    if (n_stored >= SLOTS - 1) begin
                        fault_seen = 1'b1;
                    end else begin
                        slot_len[wr_slot] = line_len;
                        wr_slot = (wr_slot + 1) % SLOTS;
                        n_stored++;
                    end
                    line_len = 0;
                end else begin
                    // overlong line starts over with this byte
                    if (line_len >= SLOT_BYTES - 1) begin
                        overlong_seen = 1'b1;
                        line_len = 0;
                    end
                    msg_mem[wr_slot*SLOT_BYTES + line_len] = rx;
                    line_len++;
                end
                r.frame_committed = (n_stored != held);
            end
            srx_pkg::KIND_READ: begin
                if (n_stored > 0 && off < oldest_len())
                    r.read_data = msg_mem[oldest_slot_idx()*SLOT_BYTES + off];
            end
            srx_pkg::KIND_RELEASE: begin
                if (n_stored > 0)
                    n_stored--;
            end
            default: ;
        endcase
        r.oldest_length   = 8'(oldest_len());
        r.messages_stored = 2'(n_stored);
        r.full_fault      = fault_seen;
        r.line_too_long   = overlong_seen;
        return r;
    endfunction

    // idle length before an item: mostly none, some short, a few long
    function automatic int pick_gap();
        int unsigned r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == srx_pkg::CODE_STX || b == srx_pkg::CODE_ETX);
        return b;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(input logic [1:0] kind, input logic [7:0] rx,
                             input logic [7:0] off);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {off, rx};
        do @(posedge aclk); while (!s_tready);
        expected_status_q.push_back(predict_status(kind, rx, off));
        items_sent++;
    endtask

    // edge values of every field, empty store, full slots, reserved kind
    task automatic test_directed();
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd0);
        send_item(srx_pkg::KIND_READ, 8'hFF, 8'd255);
        send_item(srx_pkg::KIND_RELEASE, 8'h00, 8'h00);
        send_item(KIND_UNUSED, 8'hFF, 8'hFF);
        send_item(srx_pkg::KIND_BYTE, 8'h00, 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_STX, 8'h00);
        send_item(srx_pkg::KIND_BYTE, 8'hFF, 8'hFF);
        send_item(srx_pkg::KIND_BYTE, 8'h55, 8'h00);
        send_item(srx_pkg::KIND_BYTE, 8'hAA, 8'h00);
        send_item(srx_pkg::KIND_BYTE, 8'h01, 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, 8'h00);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd0);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd3);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd4);
        send_item(srx_pkg::KIND_READ, 8'hFF, 8'd255);
        // empty message, then a byte without a start code
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_STX, 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, 8'h00);
        send_item(srx_pkg::KIND_BYTE, 8'h7E, 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, 8'h00);
        // slots full: this end code drops the line
        send_item(srx_pkg::KIND_BYTE, 8'h41, 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, 8'h00);
        send_item(KIND_UNUSED, 8'h00, 8'h00);
        repeat (4) send_item(srx_pkg::KIND_RELEASE, 8'h00, 8'h00);
    endtask

    // longest line that fits, then one byte too many
    task automatic test_long_line();
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_STX, 8'h00);
        repeat (SLOT_BYTES - 1) send_item(srx_pkg::KIND_BYTE, payload_byte(), rand_byte());
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, 8'h00);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd0);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd254);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd255);
        send_item(srx_pkg::KIND_RELEASE, 8'h00, 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_STX, 8'h00);
        repeat (SLOT_BYTES) send_item(srx_pkg::KIND_BYTE, payload_byte(), 8'h00);
        send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, 8'h00);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd0);
        send_item(srx_pkg::KIND_READ, 8'h00, 8'd1);
        send_item(srx_pkg::KIND_RELEASE, 8'h00, 8'h00);
    endtask

    // mostly framed messages with random content, reads and releases, some noise
    task automatic test_random();
        int unsigned goal;
        int unsigned choice;
        int unsigned len;
        logic [7:0]  b;
        logic [7:0]  off;
        logic [1:0]  kind;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            // switch idling on and off now and then
            if ($urandom_range(0, 59) == 0) begin
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            choice = $urandom_range(0, 99);
            if (choice < 40) begin
                if ($urandom_range(0, 9) != 0)
                    send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_STX, rand_byte());
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(0, 12);
                repeat (len) begin
                    b = ($urandom_range(0, 19) == 0) ? rand_byte() : payload_byte();
                    send_item(srx_pkg::KIND_BYTE, b, rand_byte());
                end
                if ($urandom_range(0, 19) != 0)
                    send_item(srx_pkg::KIND_BYTE, srx_pkg::CODE_ETX, rand_byte());
            end else if (choice < 70) begin
                repeat ($urandom_range(1, 4)) begin
                    off = ($urandom_range(0, 3) == 0) ? rand_byte()
                                                      : 8'($urandom_range(0, oldest_len()));
                    send_item(srx_pkg::KIND_READ, rand_byte(), off);
                end
            end else if (choice < 92) begin
                send_item(srx_pkg::KIND_RELEASE, rand_byte(), rand_byte());
            end else begin
                kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
                send_item(kind, rand_byte(), rand_byte());
            end
        end
    endtask

    // result check against the oldest prediction, and m_tready stalls
    always @(posedge aclk) begin : result_check
        rx_status_t got;
        rx_status_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_data       = m_tdata[7:0];
                got.oldest_length   = m_tdata[15:8];
                got.messages_stored = m_tdata[17:16];
                got.frame_committed = m_tdata[18];
                got.full_fault      = m_tdata[19];
                got.line_too_long   = m_tdata[20];
                if (expected_status_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result item with none expected: %p", $time, got);
                    mismatches++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.read_data !== want.read_data
                            || got.oldest_length !== want.oldest_length
                            || got.messages_stored !== want.messages_stored
                            || got.frame_committed !== want.frame_committed
                            || got.full_fault !== want.full_fault
                            || got.line_too_long !== want.line_too_long) begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_on && $urandom_range(0, 99) < 30) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                         : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        wait (aresetn === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("stx_etx_message_receiver_test: done, errors");
        $finish;
    end

    // test sequence
    initial begin
        foreach (slot_len[i])
            slot_len[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_long_line();
        test_random();
        s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("stx_etx_message_receiver_test: done, clean");
        else
            $display("stx_etx_message_receiver_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/srx_pkg.sv
sv/srx_store.sv
sv/srx_ctrl.sv
sv/srx_out.sv
sv/stx_etx_message_receiver.sv
tb/sv/stx_etx_message_receiver_test.sv
